/* rtl/fpjm_pkg.sv */
// Shared types, codes and arithmetic helpers for the frame pacing jitter monitor.
// Depends on nothing; imported by frame_pacing_jitter_monitor.
package fpjm_pkg;

  localparam int unsigned StampW = 64;
  localparam int unsigned ExtW   = 16;

  typedef enum logic [1:0] {
    PACE_UNKNOWN  = 2'd0,
    PACE_STABLE   = 2'd1,
    PACE_UNSTABLE = 2'd2,
    PACE_BAD      = 2'd3
  } pacing_class_e;

  typedef logic [StampW-1:0] word_t;
  typedef logic [ExtW-1:0]   ext_t;

  // Exact floor((old * 7 + sample) / 8), computed three bits wider.
  function automatic word_t ewma8(input word_t old, input word_t sample);
    logic [StampW+2:0] sum;
    sum = {old, 3'b000} - {3'b000, old} + {3'b000, sample};
    return sum[StampW+2:3];
  endfunction

  function automatic pacing_class_e pacing_of(input word_t avg, input word_t jit);
    pacing_class_e cls;
    if (avg == '0) begin
      cls = PACE_UNKNOWN;
    end else if (jit > (avg >> 1)) begin
      cls = PACE_BAD;
    end else if (jit > (avg >> 2)) begin
      cls = PACE_UNSTABLE;
    end else begin
      cls = PACE_STABLE;
    end
    return cls;
  endfunction

endpackage

/* rtl/frame_pacing_jitter_monitor.sv */
// Frame pacing jitter monitor: frame count, average interval and jitter per frame beat.
// Depends on fpjm_pkg for the pacing codes and the averaging helper.
//
// The block takes one frame beat per clock cycle while it is not stalled and returns
// one result beat for each, in order. The work is split into four stages ahead of
// the output register: interval and count, interval average, absolute deviation,
// and jitter average, with the pacing class formed on the way into the output
// register. Each average register updates as its frame leaves that stage, so
// back-to-back frames see each other's updates. A stall on the output fills empty
// stages first and holds off the input only when all are full.
module frame_pacing_jitter_monitor
  import fpjm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [63:0]       stamp_ns_i,
  input  logic [15:0]       new_width_i,
  input  logic [15:0]       new_height_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       frame_count_o,
  output logic [63:0]       avg_delta_ns_o,
  output logic [63:0]       jitter_ns_o,
  output logic [1:0]        pacing_class_o,
  output logic [15:0]       last_width_o,
  output logic [15:0]       last_height_o
);

  typedef struct packed {
    word_t cnt;
    ext_t  wid;
    ext_t  hgt;
    logic  upd;
    word_t delta;
  } s1_t;

  typedef struct packed {
    word_t cnt;
    ext_t  wid;
    ext_t  hgt;
    logic  upd;
    word_t delta;
    word_t avg;
  } s2_t;

  typedef struct packed {
    word_t cnt;
    ext_t  wid;
    ext_t  hgt;
    logic  upd;
    word_t diff;
    word_t avg;
  } s3_t;

  typedef struct packed {
    word_t cnt;
    ext_t  wid;
    ext_t  hgt;
    word_t avg;
    word_t jit;
  } s4_t;

  typedef struct packed {
    word_t         cnt;
    word_t         avg;
    word_t         jit;
    pacing_class_e cls;
    ext_t          wid;
    ext_t          hgt;
  } out_t;

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy_o, rdy4, rdy3, rdy2, rdy1;
  logic acc, adv1, adv2, adv3, adv4;

  word_t prev_q, avg_q, jit_q, cnt_q;
  ext_t  wid_q, hgt_q;

  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  out_t out_q, out_d;

  logic [StampW:0] sub_full;
  word_t           cnt_d, avg_d, jit_d;
  ext_t            wid_d, hgt_d;
  word_t           dev_a, dev_b;

  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign acc  = in_valid_i && rdy1;
  assign adv1 = v1_q && rdy2;
  assign adv2 = v2_q && rdy3;
  assign adv3 = v3_q && rdy4;
  assign adv4 = v4_q && rdy_o;

  assign in_stall_o = !rdy1;

  // Stage 1: interval, frame count and stored extent.
  always_comb begin
    sub_full = {1'b0, stamp_ns_i} - {1'b0, prev_q};
    cnt_d    = cnt_q + word_t'(1);
    if (new_width_i != '0 && new_height_i != '0) begin
      wid_d = new_width_i;
      hgt_d = new_height_i;
    end else begin
      wid_d = wid_q;
      hgt_d = hgt_q;
    end
    s1_d.cnt   = cnt_d;
    s1_d.wid   = wid_d;
    s1_d.hgt   = hgt_d;
    s1_d.delta = sub_full[StampW-1:0];
    s1_d.upd   = (prev_q != '0) && !sub_full[StampW] && (sub_full[StampW-1:0] != '0);
  end

  // Stage 2: interval average.
  always_comb begin
    avg_d = avg_q;
    if (s1_q.upd) begin
      avg_d = (avg_q == '0) ? s1_q.delta : ewma8(avg_q, s1_q.delta);
    end
    s2_d.cnt   = s1_q.cnt;
    s2_d.wid   = s1_q.wid;
    s2_d.hgt   = s1_q.hgt;
    s2_d.upd   = s1_q.upd;
    s2_d.delta = s1_q.delta;
    s2_d.avg   = avg_d;
  end

  // Stage 3: absolute deviation from the updated average.
  always_comb begin
    dev_a     = s2_q.delta - s2_q.avg;
    dev_b     = s2_q.avg - s2_q.delta;
    s3_d.cnt  = s2_q.cnt;
    s3_d.wid  = s2_q.wid;
    s3_d.hgt  = s2_q.hgt;
    s3_d.upd  = s2_q.upd;
    s3_d.avg  = s2_q.avg;
    s3_d.diff = (s2_q.delta > s2_q.avg) ? dev_a : dev_b;
  end

  // Stage 4: jitter average.
  always_comb begin
    jit_d = jit_q;
    if (s3_q.upd) begin
      jit_d = (jit_q == '0) ? s3_q.diff : ewma8(jit_q, s3_q.diff);
    end
    s4_d.cnt = s3_q.cnt;
    s4_d.wid = s3_q.wid;
    s4_d.hgt = s3_q.hgt;
    s4_d.avg = s3_q.avg;
    s4_d.jit = jit_d;
  end

  always_comb begin
    out_d.cnt = s4_q.cnt;
    out_d.avg = s4_q.avg;
    out_d.jit = s4_q.jit;
    out_d.cls = pacing_of(s4_q.avg, s4_q.jit);
    out_d.wid = s4_q.wid;
    out_d.hgt = s4_q.hgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vo_q   <= 1'b0;
      prev_q <= '0;
      avg_q  <= '0;
      jit_q  <= '0;
      cnt_q  <= '0;
      wid_q  <= '0;
      hgt_q  <= '0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy_o) begin
        vo_q <= v4_q;
      end
      if (acc) begin
        prev_q <= stamp_ns_i;
        cnt_q  <= cnt_d;
        wid_q  <= wid_d;
        hgt_q  <= hgt_d;
      end
      if (adv1) begin
        avg_q <= avg_d;
      end
      if (adv3) begin
        jit_q <= jit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    if (adv1) begin
      s2_q <= s2_d;
    end
    if (adv2) begin
      s3_q <= s3_d;
    end
    if (adv3) begin
      s4_q <= s4_d;
    end
    if (adv4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = vo_q;
  assign frame_count_o  = out_q.cnt;
  assign avg_delta_ns_o = out_q.avg;
  assign jitter_ns_o    = out_q.jit;
  assign pacing_class_o = out_q.cls;
  assign last_width_o   = out_q.wid;
  assign last_height_o  = out_q.hgt;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for frame_pacing_jitter_monitor: directed and random frame beats with
// random idling on both sides, checked against an in-bench model of the averages.
// Depends on fpjm_pkg and the RTL of frame_pacing_jitter_monitor.
module tb
  import fpjm_pkg::*;
;

  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    logic [63:0]   count;
    logic [63:0]   avg;
    logic [63:0]   jitter;
    pacing_class_e cls;
    logic [15:0]   width;
    logic [15:0]   height;
  } frame_stats_t;

  typedef struct {
    logic [63:0] stamp;
    logic [15:0] width;
    logic [15:0] height;
    int          gap;
    bit          drain;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] stamp_ns_i = '0;
  logic [15:0] new_width_i = '0;
  logic [15:0] new_height_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] frame_count_o;
  logic [63:0] avg_delta_ns_o;
  logic [63:0] jitter_ns_o;
  logic [1:0]  pacing_class_o;
  logic [15:0] last_width_o;
  logic [15:0] last_height_o;

  frame_beat_t  frames_todo[$];
  frame_stats_t stats_due[$];
  int           gap_left = 0;
  int           stall_left = 0;
  int           mismatches = 0;
  int unsigned  cycles = 0;

  logic [63:0] last_stamp = '0;
  logic [63:0] mean_gap = '0;
  logic [63:0] mean_dev = '0;
  logic [63:0] seen_frames = '0;
  logic [15:0] kept_w = '0;
  logic [15:0] kept_h = '0;

  frame_pacing_jitter_monitor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stamp_ns_i     (stamp_ns_i),
    .new_width_i    (new_width_i),
    .new_height_i   (new_height_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_count_o  (frame_count_o),
    .avg_delta_ns_o (avg_delta_ns_o),
    .jitter_ns_o    (jitter_ns_o),
    .pacing_class_o (pacing_class_o),
    .last_width_o   (last_width_o),
    .last_height_o  (last_height_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] smooth8(input logic [63:0] old, input logic [63:0] sample);
    logic [66:0] acc;
    acc = 67'(old) * 67'd7 + 67'(sample);
    return acc[66:3];
  endfunction

  function automatic frame_stats_t advance_pacing(input logic [63:0] stamp,
                                                  input logic [15:0] w, input logic [15:0] h);
    frame_stats_t r;
    logic [63:0]  prior;
    logic [63:0]  delta;
    logic [63:0]  dev;
    prior = last_stamp;
    last_stamp = stamp;
    if (w != 0 && h != 0) begin
      kept_w = w;
      kept_h = h;
    end
    seen_frames = seen_frames + 64'd1;
    if (prior != 0 && stamp > prior) begin
      delta = stamp - prior;
      mean_gap = (mean_gap == 0) ? delta : smooth8(mean_gap, delta);
      dev = (delta > mean_gap) ? delta - mean_gap : mean_gap - delta;
      mean_dev = (mean_dev == 0) ? dev : smooth8(mean_dev, dev);
    end
    r.count = seen_frames;
    r.avg = mean_gap;
    r.jitter = mean_dev;
    if (mean_gap == 0) begin
      r.cls = PACE_UNKNOWN;
    end else if (mean_dev > mean_gap / 64'd2) begin
      r.cls = PACE_BAD;
    end else if (mean_dev > mean_gap / 64'd4) begin
      r.cls = PACE_UNSTABLE;
    end else begin
      r.cls = PACE_STABLE;
    end
    r.width = kept_w;
    r.height = kept_h;
    return r;
  endfunction

  task automatic add_frame(input logic [63:0] stamp, input logic [15:0] w,
                           input logic [15:0] h, input int gap, input bit drain);
    frame_beat_t b;
    b.stamp = stamp;
    b.width = w;
    b.height = h;
    b.gap = gap;
    b.drain = drain;
    frames_todo.push_back(b);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      stamp_ns_i <= '0;
      new_width_i <= '0;
      new_height_i <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        stats_due.push_back(advance_pacing(stamp_ns_i, new_width_i, new_height_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (frames_todo.size() != 0 &&
                     !(frames_todo[0].drain && stats_due.size() != 0)) begin
          b = frames_todo.pop_front();
          in_valid_i <= 1'b1;
          stamp_ns_i <= b.stamp;
          new_width_i <= b.width;
          new_height_i <= b.height;
          gap_left <= b.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_stats_t want;
    int           nxt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      nxt = (stall_left > 0) ? stall_left - 1 : 0;
      if (out_valid_o && !out_stall_i) begin
        if (stats_due.size() == 0) begin
          $error("result beat with no expected frame statistics, count %0h", frame_count_o);
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          compare_field("frame_count", want.count, frame_count_o);
          compare_field("avg_delta_ns", want.avg, avg_delta_ns_o);
          compare_field("jitter_ns", want.jitter, jitter_ns_o);
          compare_field("pacing_class", 64'(want.cls), 64'(pacing_class_o));
          compare_field("last_width", 64'(want.width), 64'(last_width_o));
          compare_field("last_height", 64'(want.height), 64'(last_height_o));
        end
        nxt = (((cycles >> 9) & 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      stall_left <= nxt;
      out_stall_i <= (nxt != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [63:0] stamp;
    logic [63:0] period;
    logic [63:0] spread;
    logic [15:0] w;
    logic [15:0] h;
    int          total;
    int          run_len;
    int          pick;
    bit          quiet;
    bit          drain;

    add_frame(64'd0, 16'd0, 16'd0, 0, 0);
    add_frame(64'd1000, 16'd1920, 16'd1080, 0, 0);
    add_frame(64'd2000, 16'd0, 16'd0, 3, 0);
    add_frame(64'd3100, 16'd0, 16'd720, 0, 0);
    add_frame(64'd3100, 16'd1280, 16'd0, 0, 0);
    add_frame(64'd500, 16'd65535, 16'd65535, 5, 0);
    add_frame(64'd1500, 16'd1, 16'd1, 0, 1);
    add_frame(64'd5500, 16'd640, 16'd480, 0, 0);
    add_frame(64'd5600, 16'd640, 16'd480, 0, 0);
    add_frame(64'd6600, 16'd640, 16'd480, 0, 0);
    add_frame(64'd6650, 16'd640, 16'd480, 0, 0);
    add_frame(64'd9000, 16'd640, 16'd480, 0, 0);
    add_frame(64'hFFFF_FFFF_FFFF_FFFF, 16'hAAAA, 16'h5555, 2, 0);
    add_frame(64'd0, 16'h5555, 16'hAAAA, 0, 0);
    add_frame(64'd1, 16'd0, 16'd0, 0, 0);
    add_frame(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 0, 0);
    add_frame(64'd2, 16'd0, 16'd0, 0, 1);
    add_frame(64'h8000_0000_0000_0000, 16'd0, 16'd0, 0, 0);
    add_frame(64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 16'd0, 0, 0);
    add_frame(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 0, 0);

    total = 0;
    while (total < 1900) begin
      pick = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 2) == 0);
      drain = ($urandom_range(0, 7) == 0);
      if (pick == 0) begin
        run_len = $urandom_range(3, 12);
        for (int i = 0; i < run_len; i++) begin
          stamp = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
          add_frame(stamp, 16'($urandom), 16'($urandom), quiet ? 0 : $urandom_range(0, 11),
                    drain && i == 0);
        end
      end else begin
        run_len = $urandom_range(20, 80);
        stamp = {$urandom, $urandom} >> $urandom_range(0, 40);
        if ($urandom_range(0, 9) == 0) begin
          period = ({$urandom, $urandom} >> $urandom_range(2, 24)) + 64'd1;
        end else begin
          period = (64'($urandom) >> $urandom_range(0, 31)) + 64'd1;
        end
        spread = period >> $urandom_range(0, 6);
        w = 16'($urandom);
        h = 16'($urandom);
        for (int i = 0; i < run_len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) begin
            stamp = 64'd0;
          end else if (pick < 4) begin
            stamp = stamp - ({$urandom, $urandom} % (period + 64'd1));
          end else if (pick >= 6) begin
            stamp = stamp + period - spread / 2 + ({$urandom, $urandom} % (spread + 64'd1));
          end
          if ($urandom_range(0, 19) == 0) begin
            w = 16'($urandom);
            h = 16'($urandom);
          end
          pick = $urandom_range(0, 19);
          add_frame(stamp, (pick == 0 || pick == 2) ? 16'd0 : w,
                    (pick == 1 || pick == 2) ? 16'd0 : h,
                    quiet ? 0 : $urandom_range(0, 11), drain && i == 0);
        end
      end
      total += run_len;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (frames_todo.size() != 0 || in_valid_i || stats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
